// ===== hw/rtl/bcpc_pkg.sv =====
// shared types, codes and helpers for the button click and press classifier
`default_nettype none
package bcpc_pkg;

   localparam int TimeWidth   = 32;
   localparam int MsWidth     = 16;
   localparam int MaskWidth   = 32;
   localparam int CountWidth  = 32;
   localparam int ClicksWidth = 8;
   localparam int KindWidth   = 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 32;
   localparam int ReqDatWidth = 40;
   localparam int RspDatWidth = 40;

   localparam logic [KindWidth-1:0] KIND_NONE  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_CLICK = 2'd1;
   localparam logic [KindWidth-1:0] KIND_PRESS = 2'd2;

   localparam logic [CsrIdxWidth-1:0] CSR_ACTIVE_LEVEL = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_DEBOUNCE     = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESS_PERIOD = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_CLICK_TMO    = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_CLICK_MASK   = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_PRESS_MASK   = 3'd5;

   typedef struct packed {
      logic                 active_level;
      logic [MsWidth-1:0]   debounce_ms;
      logic [MsWidth-1:0]   press_period_ms;
      logic [MsWidth-1:0]   click_timeout_ms;
      logic [MaskWidth-1:0] click_handler_mask;
      logic [MaskWidth-1:0] press_handler_mask;
   } cfg_type;

   function automatic logic mask_has(input logic [MaskWidth-1:0] mask,
                                     input logic [CountWidth-1:0] n);
      logic [CountWidth-1:0] idx;
      idx = n - 32'd1;
      if (n == '0 || n > 32'd32) begin
         return 1'b0;
      end
      return mask[idx[4:0]];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bcpc_cfg_regs.sv =====
// configuration register file of the button classifier
`default_nettype none
module bcpc_cfg_regs
   import bcpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CsrDatWidth-1:0] csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ACTIVE_LEVEL: cfg_in.active_level       = csr_wdata[0];
            CSR_DEBOUNCE:     cfg_in.debounce_ms        = csr_wdata[MsWidth-1:0];
            CSR_PRESS_PERIOD: cfg_in.press_period_ms    = csr_wdata[MsWidth-1:0];
            CSR_CLICK_TMO:    cfg_in.click_timeout_ms   = csr_wdata[MsWidth-1:0];
            CSR_CLICK_MASK:   cfg_in.click_handler_mask = csr_wdata;
            CSR_PRESS_MASK:   cfg_in.press_handler_mask = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level       <= 1'b1;
         cfg_ff.debounce_ms        <= 16'd50;
         cfg_ff.press_period_ms    <= 16'd1000;
         cfg_ff.click_timeout_ms   <= 16'd400;
         cfg_ff.click_handler_mask <= '0;
         cfg_ff.press_handler_mask <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/bcpc_divider.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module bcpc_divider
   import bcpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [TimeWidth-1:0]  dividend,
   input  wire logic [MsWidth-1:0]    divisor,
   output logic                       done,
   output logic [CountWidth-1:0]      quotient
);

   localparam int StepWidth = $clog2(TimeWidth);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [TimeWidth-1:0]  quot_ff, quot_in;
   logic [MsWidth-1:0]    rem_ff, rem_in;
   logic [MsWidth-1:0]    dvsr_ff, dvsr_in;
   logic [MsWidth:0]      rem_shift;
   logic [MsWidth+1:0]    diff;

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_comb begin
      rem_shift = {rem_ff, quot_ff[TimeWidth-1]};
      diff      = {1'b0, rem_shift} - {2'b00, dvsr_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      dvsr_in   = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[TimeWidth-2:0], ~diff[MsWidth+1]};
         rem_in  = diff[MsWidth+1] ? rem_shift[MsWidth-1:0] : diff[MsWidth-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == StepWidth'(TimeWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/button_click_press_classifier.sv =====
// top level of the button click and long press classifier
// req channel: one button sample per request, pin level and a wrapping ms timestamp.
// rsp channel: exactly one result per request: event kind on tuser, count and
// handler flag on tdata.
// csr channel: register index and data, always ready; registers are to be
// written only while idle, which the block itself does not enforce.
// a pressed sample passes the calc and output states; a released sample passes
// calc, check and output, and when a long press is reported with a nonzero
// press period, the serial divider that turns press length into press periods
// runs between check and output, producing one quotient bit per cycle.
// req_tready returns together with rsp_tvalid, so one sample at a time.
// results leave through an output register, so the next sample is accepted
// while an earlier result still waits; if the receiver stalls longer, the
// finished result waits in the sequencer and req_tready stays low.
// reset returns all registers to their default values, clears the timing
// state and empties the output register.
`default_nettype none
module button_click_press_classifier
   import bcpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [ReqDatWidth-1:0] req_tdata,  // pin_level, now_ms, zero pad
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RspDatWidth-1:0]      rsp_tdata,  // event_count, handler_found, zero pad
   output logic [KindWidth-1:0]        rsp_tuser,  // event_kind
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CsrDatWidth-1:0] csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CALC  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_OUT   = 3'd4;

   cfg_type cfg;

   logic [2:0]             state_ff, state_in;
   logic                   level_ff, level_in;
   logic [TimeWidth-1:0]   now_ff, now_in;
   logic [TimeWidth-1:0]   pressed_time_ff, pressed_time_in;
   logic [TimeWidth-1:0]   released_time_ff, released_time_in;
   logic [TimeWidth-1:0]   press_length_ff, press_length_in;
   logic [TimeWidth-1:0]   idle_length_ff, idle_length_in;
   logic [ClicksWidth-1:0] click_count_ff, click_count_in;
   logic                   click_taken_ff, click_taken_in;
   logic [KindWidth-1:0]   kind_ff, kind_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic                   found_ff, found_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KindWidth-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [CountWidth-1:0]  rsp_count_ff, rsp_count_in;
   logic                   rsp_found_ff, rsp_found_in;

   logic                   div_start;
   logic                   div_done;
   logic [CountWidth-1:0]  div_quot;
   logic [CountWidth-1:0]  clicks_wide;

   bcpc_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bcpc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (press_length_ff),
      .divisor  (cfg.press_period_ms),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {7'b0000000, rsp_found_ff, rsp_count_ff};
   assign rsp_tuser   = rsp_kind_ff;
   assign clicks_wide = {{(CountWidth-ClicksWidth){1'b0}}, click_count_ff};

   always_comb begin
      state_in         = state_ff;
      level_in         = level_ff;
      now_in           = now_ff;
      pressed_time_in  = pressed_time_ff;
      released_time_in = released_time_ff;
      press_length_in  = press_length_ff;
      idle_length_in   = idle_length_ff;
      click_count_in   = click_count_ff;
      click_taken_in   = click_taken_ff;
      kind_in          = kind_ff;
      count_in         = count_ff;
      found_in         = found_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_found_in     = rsp_found_ff;
      div_start        = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               level_in = req_tdata[0];
               now_in   = req_tdata[TimeWidth:1];
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            kind_in  = KIND_NONE;
            count_in = '0;
            found_in = 1'b0;
            if (level_ff == cfg.active_level) begin
               pressed_time_in = now_ff;
               press_length_in = now_ff - released_time_ff;
               click_taken_in  = 1'b0;
               state_in        = S_OUT;
            end else begin
               released_time_in = now_ff;
               idle_length_in   = now_ff - pressed_time_ff;
               if (press_length_ff > {16'd0, cfg.debounce_ms} &&
                   press_length_ff < {16'd0, cfg.press_period_ms} && !click_taken_ff) begin
                  if (click_count_ff != '1) begin
                     click_count_in = click_count_ff + 1'b1;
                  end
                  click_taken_in = 1'b1;
               end
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (click_count_ff != '0 &&
                         idle_length_ff > {16'd0, cfg.click_timeout_ms}) begin
               kind_in         = KIND_CLICK;
               count_in        = clicks_wide;
               found_in        = mask_has(cfg.click_handler_mask, clicks_wide);
               click_count_in  = '0;
               press_length_in = '0;
               idle_length_in  = '0;
               state_in        = S_OUT;
            end else if (press_length_ff >= {16'd0, cfg.press_period_ms}) begin
               kind_in = KIND_PRESS;
               if (cfg.press_period_ms == '0) begin
                  count_in        = '1;
                  found_in        = mask_has(cfg.press_handler_mask, '1);
                  click_count_in  = '0;
                  press_length_in = '0;
                  idle_length_in  = '0;
                  state_in        = S_OUT;
               end else begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               count_in        = div_quot;
               found_in        = mask_has(cfg.press_handler_mask, div_quot);
               click_count_in  = '0;
               press_length_in = '0;
               idle_length_in  = '0;
               state_in        = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_count_in = count_ff;
               rsp_found_in = found_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         rsp_valid_ff     <= 1'b0;
         pressed_time_ff  <= '0;
         released_time_ff <= '0;
         press_length_ff  <= '0;
         idle_length_ff   <= '0;
         click_count_ff   <= '0;
         click_taken_ff   <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         pressed_time_ff  <= pressed_time_in;
         released_time_ff <= released_time_in;
         press_length_ff  <= press_length_in;
         idle_length_ff   <= idle_length_in;
         click_count_ff   <= click_count_in;
         click_taken_ff   <= click_taken_in;
      end
      level_ff     <= level_in;
      now_ff       <= now_in;
      kind_ff      <= kind_in;
      count_ff     <= count_in;
      found_ff     <= found_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_count_ff <= rsp_count_in;
      rsp_found_ff <= rsp_found_in;
   end

endmodule
`default_nettype wire

// ===== verif/tb_button_click_press_classifier.sv =====
// self-checking testbench for the button click and long press classifier
`default_nettype none
module tb_button_click_press_classifier
   import bcpc_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallAtResult = 600;
   localparam int StallCycles   = 400;
   localparam int NumSettings   = 8;

   typedef struct packed {
      logic                  level;
      logic [TimeWidth-1:0]  now_ms;
   } sample_type;

   typedef struct packed {
      logic [KindWidth-1:0]  kind;
      logic [CountWidth-1:0] count;
      logic                  found;
   } btn_event_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDatWidth-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDatWidth-1:0] rsp_tdata;
   logic [KindWidth-1:0]   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index  = '0;
   logic [CsrDatWidth-1:0] csr_wdata  = '0;

   button_click_press_classifier uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // classifier copy: registers and timing state
   cfg_type              cfg;
   logic [TimeWidth-1:0] last_press_at;
   logic [TimeWidth-1:0] last_release_at;
   logic [TimeWidth-1:0] hold_len;
   logic [TimeWidth-1:0] idle_len;
   logic [7:0]           click_tally;
   logic                 click_counted;

   sample_type           sample_queue[$];
   btn_event_type        expected_events[$];
   sample_type           in_flight;
   btn_event_type        got_event;
   btn_event_type        want_event;

   int                   send_idle_pct = 0;
   int                   recv_idle_pct = 0;
   int                   stall_left    = 0;
   bit                   stall_done    = 0;
   int                   fail_count    = 0;
   int                   samples_taken = 0;
   int                   results_seen  = 0;
   int                   click_reports = 0;
   int                   press_reports = 0;
   int                   handler_hits  = 0;
   int                   seg_items     = 0;
   logic [TimeWidth-1:0] t_ms;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic handler_bit(input logic [MaskWidth-1:0] mask,
                                        input logic [CountWidth-1:0] n);
      if (n == 0 || n > 32) return 1'b0;
      return mask[n-1];
   endfunction

   function automatic void classify_sample(input sample_type s);
      btn_event_type ev;
      ev = '0;
      if (s.level == cfg.active_level) begin
         last_press_at = s.now_ms;
         hold_len      = s.now_ms - last_release_at;
         click_counted = 1'b0;
      end else begin
         last_release_at = s.now_ms;
         idle_len        = s.now_ms - last_press_at;
         if (hold_len > cfg.debounce_ms && hold_len < cfg.press_period_ms && !click_counted) begin
            if (click_tally != 8'd255) click_tally = click_tally + 8'd1;
            click_counted = 1'b1;
         end
         if (click_tally != 0 && idle_len > cfg.click_timeout_ms) begin
            ev.kind  = KIND_CLICK;
            ev.count = click_tally;
            ev.found = handler_bit(cfg.click_handler_mask, ev.count);
         end else if (hold_len >= cfg.press_period_ms) begin
            ev.kind  = KIND_PRESS;
            ev.count = (cfg.press_period_ms == 0) ? '1 : hold_len / cfg.press_period_ms;
            ev.found = handler_bit(cfg.press_handler_mask, ev.count);
         end
         if (ev.kind != KIND_NONE) begin
            click_tally = '0;
            hold_len    = '0;
            idle_len    = '0;
         end
      end
      if (ev.kind == KIND_CLICK) click_reports++;
      if (ev.kind == KIND_PRESS) press_reports++;
      if (ev.found) handler_hits++;
      expected_events.push_back(ev);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            classify_sample(in_flight);
            samples_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = sample_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'b0, in_flight.now_ms, in_flight.level};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (results_seen >= StallAtResult && !stall_done) begin
            stall_left <= StallCycles;
            stall_done <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_event.kind  = rsp_tuser;
            got_event.count = rsp_tdata[31:0];
            got_event.found = rsp_tdata[32];
            results_seen++;
            if (expected_events.size() == 0) begin
               $error("unexpected result: event_kind %0d event_count %0d handler_found %0d",
                      got_event.kind, got_event.count, got_event.found);
               fail_count++;
            end else begin
               want_event = expected_events.pop_front();
               if (got_event.kind !== want_event.kind) begin
                  $error("event_kind: expected %0d, actual %0d", want_event.kind, got_event.kind);
                  fail_count++;
               end
               if (got_event.count !== want_event.count) begin
                  $error("event_count: expected %0d, actual %0d",
                         want_event.count, got_event.count);
                  fail_count++;
               end
               if (got_event.found !== want_event.found) begin
                  $error("handler_found: expected %0d, actual %0d",
                         want_event.found, got_event.found);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic write_reg(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDatWidth-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ACTIVE_LEVEL: cfg.active_level       = value[0];
         CSR_DEBOUNCE:     cfg.debounce_ms        = value[MsWidth-1:0];
         CSR_PRESS_PERIOD: cfg.press_period_ms    = value[MsWidth-1:0];
         CSR_CLICK_TMO:    cfg.click_timeout_ms   = value[MsWidth-1:0];
         CSR_CLICK_MASK:   cfg.click_handler_mask = value;
         CSR_PRESS_MASK:   cfg.press_handler_mask = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic act, input int deb, input int per, input int tmo,
                                 input logic [MaskWidth-1:0] cmask,
                                 input logic [MaskWidth-1:0] pmask);
      write_reg(CSR_ACTIVE_LEVEL, {31'b0, act});
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_PRESS_PERIOD, per);
      write_reg(CSR_CLICK_TMO, tmo);
      write_reg(CSR_CLICK_MASK, cmask);
      write_reg(CSR_PRESS_MASK, pmask);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_tvalid || expected_events.size() != 0);
   endtask

   task automatic add_at(input bit pressed, input logic [TimeWidth-1:0] now);
      sample_type s;
      s.level  = pressed ? cfg.active_level : ~cfg.active_level;
      s.now_ms = now;
      t_ms     = now;
      sample_queue.push_back(s);
      seg_items++;
   endtask

   task automatic add_after(input bit pressed, input logic [TimeWidth-1:0] delta);
      add_at(pressed, t_ms + delta);
   endtask

   // press lasting len ms from the last release, split over one to three samples
   task automatic add_press(input logic [TimeWidth-1:0] len);
      int                   parts;
      logic [TimeWidth-1:0] left;
      logic [TimeWidth-1:0] step;
      parts = $urandom_range(1, 3);
      left  = len;
      for (int i = 0; i < parts; i++) begin
         step = (i == parts - 1) ? left : $urandom_range(left, 0);
         left = left - step;
         add_after(1, step);
      end
   endtask

   task automatic add_gesture();
      int                   pick;
      int                   n;
      int                   per;
      int                   deb;
      int                   tmo;
      logic [TimeWidth-1:0] len;
      sample_type           s;
      pick = $urandom_range(99);
      per  = cfg.press_period_ms;
      deb  = cfg.debounce_ms;
      tmo  = cfg.click_timeout_ms;
      if (pick < 50) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(7))
               0: len = deb;
               1: len = deb + 1;
               2: len = per - 1;
               3: len = per;
               default: len = (per > deb + 1) ? $urandom_range(per - 1, deb + 1)
                                              : $urandom_range(100, 0);
            endcase
            add_press(len);
            add_after(0, $urandom_range(tmo, 0));
         end
         if ($urandom_range(5) != 0) add_after(0, tmo + 1 + $urandom_range(200, 0));
      end else if (pick < 75) begin
         n   = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
         len = (per == 0) ? $urandom_range(5000, 0) : n * per + $urandom_range(per, 0);
         add_press(len);
         add_after(0, $urandom_range(50, 0));
      end else begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(3))
               0: t_ms = t_ms + $urandom_range(3, 0);
               1: t_ms = $urandom;
               2: t_ms = t_ms + $urandom_range(3000, 0);
               default: t_ms = t_ms - $urandom_range(3, 0);
            endcase
            s.level  = $urandom_range(1);
            s.now_ms = t_ms;
            sample_queue.push_back(s);
            seg_items++;
         end
      end
   endtask

   task automatic directed_samples();
      add_at(0, 32'd0);
      add_at(1, 32'd100);
      add_at(0, 32'd150);
      add_at(1, 32'd300);
      add_at(0, 32'd320);
      add_at(0, 32'd800);
      add_at(1, 32'd1800);
      add_at(0, 32'd1900);
      add_at(1, 32'd1920);
      add_at(0, 32'd1930);
      add_at(1, 32'd33930);
      add_at(0, 32'd33940);
      add_at(1, 32'd66940);
      add_at(0, 32'd66950);
      // timestamps crossing the wrap
      add_at(1, 32'hFFFF_FF00);
      add_at(0, 32'hFFFF_FFFF);
      add_at(1, 32'd200);
      add_at(0, 32'd250);
      // press equal to debounce, then burst timeout
      add_at(1, 32'd300);
      add_at(0, 32'd1000);
      // click pending while a long press also ends
      add_at(1, 32'd1100);
      add_at(0, 32'd1150);
      add_at(1, 32'd3000);
      add_at(0, 32'd3500);
      add_at(1, 32'd3500);
      add_at(0, 32'd3500);
   endtask

   initial begin
      int target;
      cfg = '{active_level: 1'b1, debounce_ms: 16'd50, press_period_ms: 16'd1000,
              click_timeout_ms: 16'd400, click_handler_mask: '0, press_handler_mask: '0};
      last_press_at   = '0;
      last_release_at = '0;
      hold_len        = '0;
      idle_len        = '0;
      click_tally     = '0;
      click_counted   = 1'b0;
      t_ms            = $urandom;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int seg = 0; seg < NumSettings; seg++) begin
         wait_idle();
         case (seg)
            0: apply_settings(1'b1, 50, 1000, 400, 32'h0000_0006, 32'h8000_0001);
            1: apply_settings(1'b0, 0, 1, 0, '1, '1);
            2: apply_settings(1'b1, 10, 0, 30, 32'h5555_5555, 32'hAAAA_AAAA);
            3: apply_settings(1'b0, 100, 65535, 65535, $urandom, $urandom);
            4: apply_settings(1'b1, 65535, 65535, 0, $urandom, $urandom);
            7: apply_settings($urandom_range(1), $urandom_range(40), $urandom_range(20, 1),
                              $urandom_range(60), $urandom, $urandom);
            default: apply_settings($urandom_range(1), $urandom_range(300),
                                    $urandom_range(3000, 1), $urandom_range(1500),
                                    $urandom, $urandom);
         endcase
         @(negedge clock);
         send_idle_pct = (seg < 3) ? 29 : (seg < 6) ? 57 : 0;
         recv_idle_pct = (seg < 3) ? 57 : (seg < 6) ? 29 : 0;
         seg_items     = 0;
         target        = 110;
         if (seg == 0) begin
            directed_samples();
            target = 130;
         end
         if (seg == 3) begin
            // click count runs into saturation
            add_after(0, 10);
            for (int i = 0; i < 270; i++) begin
               add_after(1, $urandom_range(2000, 101));
               add_after(0, $urandom_range(100, 1));
            end
            add_after(0, 32'd65536 + $urandom_range(100, 0));
            target = seg_items + 60;
         end
         while (seg_items < target) add_gesture();
      end

      wait_idle();
      repeat (40) @(posedge clock);
      $display("covered %0d samples under %0d register settings", samples_taken, NumSettings);
      $display("reports: %0d click bursts, %0d long presses, %0d with a handler",
               click_reports, press_reports, handler_hits);
      if (fail_count == 0 && expected_events.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
`default_nettype wire
